>>> rtl/crf_pkg.sv
package crf_pkg;

    // Access codes carried in the mode field.
    localparam logic [2:0] MODE_CR_RD    = 3'd0;
    localparam logic [2:0] MODE_CR_WR    = 3'd1;
    localparam logic [2:0] MODE_SP_RD    = 3'd2;
    localparam logic [2:0] MODE_SP_WR    = 3'd3;
    localparam logic [2:0] MODE_ACC_RD   = 3'd4;
    localparam logic [2:0] MODE_ACC_WR   = 3'd5;

    // Control register numbers.
    localparam logic [3:0] CR_PSW    = 4'd0;
    localparam logic [3:0] CR_CBR    = 4'd1;
    localparam logic [3:0] CR_SPI    = 4'd2;
    localparam logic [3:0] CR_SPU    = 4'd3;
    localparam logic [3:0] CR_SPARE0 = 4'd4;
    localparam logic [3:0] CR_SPARE1 = 4'd5;
    localparam logic [3:0] CR_BPC    = 4'd6;
    localparam logic [3:0] CR_BBPC   = 4'd7;
    localparam logic [3:0] CR_BBPSW  = 4'd8;

    // Bit masks used on reads.
    localparam logic [7:0]  BPSW_MASK = 8'hc1;
    localparam logic [7:0]  PSW_MASK  = 8'hc0;
    localparam logic [31:0] PC_MASK   = 32'hffff_fffe;

    // Stack-mode bit of the PSW byte and sign bit of the accumulator.
    localparam int SM_BIT      = 7;
    localparam int ACC_SIGN_BIT = 55;

    typedef logic [2:0]  mode_t;
    typedef logic [3:0]  reg_index_t;
    typedef logic [63:0] data_t;

    // One access as it travels from the request side into the register file.
    typedef struct packed {
        mode_t      mode;
        reg_index_t reg_index;
        data_t      write_data;
    } item_t;

endpackage

>>> rtl/crf_if.sv
// Request channel: one access per word.
interface crf_req_if;
    logic                valid;
    logic                ready;
    crf_pkg::mode_t      mode;
    crf_pkg::reg_index_t reg_index;
    crf_pkg::data_t      write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input mode, input reg_index, input write_data,
                  output ready);
endinterface

// Response channel: one read value per word.
interface crf_rsp_if;
    logic           valid;
    logic           ready;
    crf_pkg::data_t read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

>>> rtl/crf_core.sv
module crf_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  crf_pkg::item_t item,
    output crf_pkg::data_t read_data
);
    import crf_pkg::*;

    logic [7:0]  psw_reg,   psw_next;
    logic [7:0]  bpsw_reg,  bpsw_next;
    logic [7:0]  bbpsw_reg, bbpsw_next;
    logic        cond_reg,  cond_next;
    logic [31:0] sp_reg,    sp_next;
    logic [31:0] spi_reg,   spi_next;
    logic [31:0] spu_reg,   spu_next;
    logic [31:0] bpc_reg,   bpc_next;
    logic [31:0] bbpc_reg,  bbpc_next;
    logic [31:0] spare0_reg, spare0_next;
    logic [31:0] spare1_reg, spare1_next;
    logic [63:0] acc_reg,   acc_next;

    logic [31:0] wdata32;
    logic        user_live;
    logic        new_sm;
    logic [31:0] cr_value;

    assign wdata32   = item.write_data[31:0];
    assign user_live = psw_reg[SM_BIT];
    assign new_sm    = wdata32[SM_BIT];

    // Control register read mux.
    always_comb
    begin
        unique case (item.reg_index)
            CR_PSW:    cr_value = {16'd0, bpsw_reg & BPSW_MASK,
                                   (psw_reg & PSW_MASK) | {7'd0, cond_reg}};
            CR_CBR:    cr_value = {31'd0, cond_reg};
            CR_SPI:    cr_value = user_live ? spi_reg : sp_reg;
            CR_SPU:    cr_value = user_live ? sp_reg : spu_reg;
            CR_SPARE0: cr_value = spare0_reg;
            CR_SPARE1: cr_value = spare1_reg;
            CR_BPC:    cr_value = bpc_reg & PC_MASK;
            CR_BBPC:   cr_value = bbpc_reg & PC_MASK;
            CR_BBPSW:  cr_value = {24'd0, bbpsw_reg & BPSW_MASK};
            default:   cr_value = '0;
        endcase
    end

    // Result of the access; writes and unused modes return zero.
    always_comb
    begin
        unique case (item.mode)
            MODE_CR_RD:  read_data = {32'd0, cr_value};
            MODE_SP_RD:  read_data = {32'd0, sp_reg};
            MODE_ACC_RD: read_data = {{(63 - ACC_SIGN_BIT){acc_reg[ACC_SIGN_BIT]}},
                                      acc_reg[ACC_SIGN_BIT:0]};
            default:     read_data = '0;
        endcase
    end

    // Next state for a write access.
    always_comb
    begin
        psw_next    = psw_reg;
        bpsw_next   = bpsw_reg;
        bbpsw_next  = bbpsw_reg;
        cond_next   = cond_reg;
        sp_next     = sp_reg;
        spi_next    = spi_reg;
        spu_next    = spu_reg;
        bpc_next    = bpc_reg;
        bbpc_next   = bbpc_reg;
        spare0_next = spare0_reg;
        spare1_next = spare1_reg;
        acc_next    = acc_reg;
        unique case (item.mode)
            MODE_CR_WR:
            begin
                unique case (item.reg_index)
                    CR_PSW:
                    begin
                        bpsw_next = wdata32[15:8];
                        psw_next  = wdata32[7:0];
                        cond_next = wdata32[0];
                        // A change of stack mode swaps the live pointer with a shadow.
                        if (user_live != new_sm)
                        begin
                            if (user_live)
                            begin
                                spu_next = sp_reg;
                                sp_next  = spi_reg;
                            end
                            else
                            begin
                                spi_next = sp_reg;
                                sp_next  = spu_reg;
                            end
                        end
                    end
                    CR_CBR:    cond_next = wdata32[0];
                    CR_SPI:
                    begin
                        if (user_live)
                            spi_next = wdata32;
                        else
                            sp_next = wdata32;
                    end
                    CR_SPU:
                    begin
                        if (user_live)
                            sp_next = wdata32;
                        else
                            spu_next = wdata32;
                    end
                    CR_SPARE0: spare0_next = wdata32;
                    CR_SPARE1: spare1_next = wdata32;
                    CR_BPC:    bpc_next = wdata32;
                    CR_BBPC:   bbpc_next = wdata32;
                    CR_BBPSW:  bbpsw_next = wdata32[7:0];
                    default:   ;
                endcase
            end
            MODE_SP_WR:  sp_next = wdata32;
            MODE_ACC_WR: acc_next = item.write_data;
            default:     ;
        endcase
    end

    // Architectural state, updated once per access.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psw_reg    <= '0;
            bpsw_reg   <= '0;
            bbpsw_reg  <= '0;
            cond_reg   <= 1'b0;
            sp_reg     <= '0;
            spi_reg    <= '0;
            spu_reg    <= '0;
            bpc_reg    <= '0;
            bbpc_reg   <= '0;
            spare0_reg <= '0;
            spare1_reg <= '0;
            acc_reg    <= '0;
        end
        else if (fire)
        begin
            psw_reg    <= psw_next;
            bpsw_reg   <= bpsw_next;
            bbpsw_reg  <= bbpsw_next;
            cond_reg   <= cond_next;
            sp_reg     <= sp_next;
            spi_reg    <= spi_next;
            spu_reg    <= spu_next;
            bpc_reg    <= bpc_next;
            bbpc_reg   <= bbpc_next;
            spare0_reg <= spare0_next;
            spare1_reg <= spare1_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

>>> rtl/control_register_file_sp_banking.sv
// Channel | Dir | Payload                         | Handshake
// req     | in  | mode, reg_index, write_data     | valid/ready
// rsp     | out | read_data                       | valid/ready
//
// Each word passes an input register and then a result register, which offers
// the response; one word per cycle is sustained while rsp.ready stays high, set
// by the single read-and-update pass over the register file.
// Reset (rst_n low) clears all register-file registers to zero and empties both stages.
// A stalled response holds its word; the input stage keeps accepting while the
// result register is free or being drained in the same cycle.
module control_register_file_sp_banking (
    input logic       clk,
    input logic       rst_n,
    crf_req_if.sink   req,
    crf_rsp_if.source rsp
);
    import crf_pkg::*;

    logic  s1_valid_reg;
    item_t s1_item_reg;
    logic  out_valid_reg;
    data_t out_data_reg;
    logic  advance;
    data_t rd_value;

    // The input stage moves on when the result register can take its word.
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_item_reg.mode       <= req.mode;
            s1_item_reg.reg_index  <= req.reg_index;
            s1_item_reg.write_data <= req.write_data;
        end
    end

    crf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (s1_item_reg),
        .read_data (rd_value)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= rd_value;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

endmodule

>>> tb/sv/control_register_file_sp_banking_tb.sv
`timescale 1ns / 1ps

module control_register_file_sp_banking_tb;

    import crf_pkg::*;

    // Mode codes that the block treats as no-ops.
    localparam mode_t MODE_UNUSED_LO = 3'd6;
    localparam mode_t MODE_UNUSED_HI = 3'd7;

    // Register numbers past the last implemented control register.
    localparam reg_index_t CR_UNKNOWN_FIRST = 4'd9;
    localparam reg_index_t CR_UNKNOWN_LAST  = 4'd15;

    localparam int IDLE_MAX      = 13;
    localparam int DRAIN_CYCLES  = 20;
    localparam int BACKLOG_HOLD  = 150;
    localparam int BACKLOG_WORDS = 100;

    logic clk = 1'b0;
    logic rst_n;

    crf_req_if req_bus ();
    crf_rsp_if rsp_bus ();

    control_register_file_sp_banking dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the register file.
    logic [7:0]  psw_lo    = '0;
    logic [7:0]  psw_hi    = '0;
    logic [7:0]  bbpsw_q   = '0;
    logic        cond_q    = 1'b0;
    logic [31:0] sp_live   = '0;
    logic [31:0] sp_isave  = '0;
    logic [31:0] sp_usave  = '0;
    logic [31:0] bpc_q     = '0;
    logic [31:0] bbpc_q    = '0;
    logic [31:0] spare_q [2] = '{32'h0, 32'h0};
    data_t       acc_q     = '0;

    item_t pending_words [$];
    data_t read_expect_q [$];

    int queued_total = 0;
    int taken_total  = 0;
    int fail_count   = 0;

    logic req_acc = 1'b0;
    logic rsp_acc = 1'b0;
    bit   send_idle_on = 1'b1;
    bit   recv_idle_on = 1'b1;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   hold_asks = 0;
    int   hold_served = 0;
    int   hold_left = 0;

    // Applies one access to the shadow registers and returns the value read back.
    function automatic data_t apply_access(mode_t op, reg_index_t idx, data_t wdata);
        logic [31:0] v;
        logic        user_live;
        data_t       rd;
        v = wdata[31:0];
        user_live = psw_lo[SM_BIT];
        rd = '0;
        case (op)
            MODE_CR_RD:
            begin
                case (idx)
                    CR_PSW:    rd = {48'b0, psw_hi & BPSW_MASK,
                                     (psw_lo & PSW_MASK) | {7'b0, cond_q}};
                    CR_CBR:    rd = {63'b0, cond_q};
                    CR_SPI:    rd = {32'b0, user_live ? sp_isave : sp_live};
                    CR_SPU:    rd = {32'b0, user_live ? sp_live : sp_usave};
                    CR_SPARE0: rd = {32'b0, spare_q[0]};
                    CR_SPARE1: rd = {32'b0, spare_q[1]};
                    CR_BPC:    rd = {32'b0, bpc_q & PC_MASK};
                    CR_BBPC:   rd = {32'b0, bbpc_q & PC_MASK};
                    CR_BBPSW:  rd = {56'b0, bbpsw_q & BPSW_MASK};
                    default:   rd = '0;
                endcase
            end
            MODE_CR_WR:
            begin
                case (idx)
                    CR_PSW:
                    begin
                        // Leaving a bank saves the live pointer and loads the other one.
                        if (v[SM_BIT] != user_live)
                        begin
                            if (user_live)
                            begin
                                sp_usave = sp_live;
                                sp_live  = sp_isave;
                            end
                            else
                            begin
                                sp_isave = sp_live;
                                sp_live  = sp_usave;
                            end
                        end
                        psw_hi = v[15:8];
                        psw_lo = v[7:0];
                        cond_q = v[0];
                    end
                    CR_CBR:    cond_q = v[0];
                    CR_SPI:
                    begin
                        if (user_live)
                            sp_isave = v;
                        else
                            sp_live = v;
                    end
                    CR_SPU:
                    begin
                        if (user_live)
                            sp_live = v;
                        else
                            sp_usave = v;
                    end
                    CR_SPARE0: spare_q[0] = v;
                    CR_SPARE1: spare_q[1] = v;
                    CR_BPC:    bpc_q = v;
                    CR_BBPC:   bbpc_q = v;
                    CR_BBPSW:  bbpsw_q = v[7:0];
                    default:   ;
                endcase
            end
            MODE_SP_RD:  rd = {32'b0, sp_live};
            MODE_SP_WR:  sp_live = v;
            MODE_ACC_RD: rd = {{(63 - ACC_SIGN_BIT){acc_q[ACC_SIGN_BIT]}},
                               acc_q[ACC_SIGN_BIT:0]};
            MODE_ACC_WR: acc_q = wdata;
            default:     ;
        endcase
        return rd;
    endfunction

    function automatic int idle_draw(bit enabled);
        return enabled ? $urandom_range(0, IDLE_MAX) : 0;
    endfunction

    task automatic queue_access(mode_t op, reg_index_t idx, data_t wdata);
        item_t w;
        w.mode = op;
        w.reg_index = idx;
        w.write_data = wdata;
        pending_words.push_back(w);
        queued_total++;
    endtask

    // Random accesses, weighted toward PSW writes and stack-pointer traffic so
    // that the bank switch is exercised with live data in both banks.
    task automatic queue_random(int count);
        int    pick;
        mode_t op;
        reg_index_t idx;
        data_t wdata;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            wdata = {$urandom, $urandom};
            idx = reg_index_t'($urandom_range(0, 15));
            if (pick < 30)
            begin
                op = MODE_CR_WR;
                if ($urandom_range(0, 2) == 0)
                    idx = CR_PSW;
            end
            else if (pick < 55)
                op = MODE_CR_RD;
            else if (pick < 65)
                op = MODE_SP_RD;
            else if (pick < 73)
                op = MODE_SP_WR;
            else if (pick < 82)
                op = MODE_ACC_RD;
            else if (pick < 92)
                op = MODE_ACC_WR;
            else
                op = $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
            queue_access(op, idx, wdata);
        end
    endtask

    // Request driver: offers one word at a time and holds it until taken.
    always @(negedge clk)
    begin
        item_t w;
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (req_bus.valid && !req_acc)
            ;
        else if (send_wait > 0)
        begin
            send_wait--;
            req_bus.valid <= 1'b0;
        end
        else if (pending_words.size() > 0)
        begin
            w = pending_words.pop_front();
            req_bus.mode       <= w.mode;
            req_bus.reg_index  <= w.reg_index;
            req_bus.write_data <= w.write_data;
            req_bus.valid      <= 1'b1;
            send_wait = idle_draw(send_idle_on);
        end
        else
            req_bus.valid <= 1'b0;
    end

    // Response receiver: random stalls per word, plus a long hold on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            if (rsp_acc)
                recv_wait = idle_draw(recv_idle_on);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                hold_left = BACKLOG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Monitor: checks each returned word, then predicts each accepted request.
    always @(posedge clk)
    begin
        data_t want;
        if (!rst_n)
        begin
            req_acc <= 1'b0;
            rsp_acc <= 1'b0;
        end
        else
        begin
            req_acc <= req_bus.valid && req_bus.ready;
            rsp_acc <= rsp_bus.valid && rsp_bus.ready;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (read_expect_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected read_data word, expected none, got %h",
                             $time, rsp_bus.read_data);
                end
                else
                begin
                    want = read_expect_q.pop_front();
                    if (rsp_bus.read_data !== want)
                    begin
                        fail_count++;
                        $display("%0t: read_data mismatch, expected %h, got %h",
                                 $time, want, rsp_bus.read_data);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                read_expect_q.push_back(apply_access(req_bus.mode, req_bus.reg_index,
                                                     req_bus.write_data));
                taken_total++;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.mode = MODE_CR_RD;
        req_bus.reg_index = CR_PSW;
        req_bus.write_data = '0;
        rsp_bus.ready = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Accumulator sign extension at both signs of bit 55.
        queue_access(MODE_ACC_WR, CR_PSW, 64'h0080_0000_0000_0000);
        queue_access(MODE_ACC_RD, CR_PSW, 64'hffff_ffff_ffff_ffff);
        queue_access(MODE_ACC_WR, CR_PSW, 64'hff7f_ffff_ffff_ffff);
        queue_access(MODE_ACC_RD, CR_PSW, '0);
        // Upper write bits are dropped for 32-bit targets.
        queue_access(MODE_SP_WR, CR_PSW, 64'hffff_ffff_1234_5679);
        queue_access(MODE_CR_WR, CR_SPU, 64'hffff_0000_89ab_cdef);
        // Enter the user bank, look at both pointers, then return.
        queue_access(MODE_CR_WR, CR_PSW, 64'hffff_ffff_0000_ffff);
        queue_access(MODE_CR_RD, CR_PSW, '0);
        queue_access(MODE_CR_RD, CR_SPI, '0);
        queue_access(MODE_CR_RD, CR_SPU, '0);
        queue_access(MODE_CR_WR, CR_SPI, 64'h0000_0000_dead_beef);
        queue_access(MODE_SP_RD, CR_PSW, '0);
        queue_access(MODE_CR_WR, CR_PSW, '0);
        queue_access(MODE_CR_RD, CR_SPI, '0);
        queue_access(MODE_CR_RD, CR_SPU, '0);
        queue_access(MODE_CR_WR, CR_CBR, 64'hffff_ffff_ffff_ffff);
        queue_access(MODE_CR_RD, CR_CBR, '0);
        queue_access(MODE_CR_WR, CR_BPC, 64'hffff_ffff_ffff_ffff);
        queue_access(MODE_CR_WR, CR_BBPC, 64'h0000_0000_8000_0001);
        queue_access(MODE_CR_WR, CR_BBPSW, 64'h0000_0000_ffff_ffff);
        queue_access(MODE_CR_WR, CR_SPARE1, 64'h0000_0000_5a5a_a5a5);
        queue_access(MODE_CR_WR, CR_UNKNOWN_LAST, 64'hffff_ffff_ffff_ffff);
        queue_access(MODE_CR_RD, CR_UNKNOWN_FIRST, '0);
        queue_access(MODE_UNUSED_LO, CR_PSW, 64'hffff_ffff_ffff_ffff);
        queue_access(MODE_UNUSED_HI, CR_BPC, 64'hffff_ffff_ffff_ffff);
        wait (taken_total == queued_total && read_expect_q.size() == 0);

        // Random traffic with both sides idling.
        queue_random(350);
        wait (taken_total == queued_total && read_expect_q.size() == 0);

        // Back up the pipeline: sender never idles while the receiver holds off.
        send_idle_on = 1'b0;
        queue_random(BACKLOG_WORDS);
        hold_asks++;
        wait (taken_total == queued_total && read_expect_q.size() == 0);

        // Full-rate stretch with no idling on either side.
        recv_idle_on = 1'b0;
        queue_random(450);
        wait (taken_total == queued_total && read_expect_q.size() == 0);

        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        queue_random(475);
        wait (taken_total == queued_total && read_expect_q.size() == 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && read_expect_q.size() == 0)
            $display("control_register_file_sp_banking verification clean");
        else
            $display("control_register_file_sp_banking verification failed");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #2_000_000;
        $display("control_register_file_sp_banking verification failed");
        $finish;
    end

endmodule

>>> control_register_file_sp_banking.f
rtl/crf_pkg.sv
rtl/crf_if.sv
rtl/crf_core.sv
rtl/control_register_file_sp_banking.sv
tb/sv/control_register_file_sp_banking_tb.sv
